### hw/rtl/fwq_pkg.sv
`default_nettype none

package fwq_pkg;

	// Default sizes of the table
	localparam int DEF_WAITER_SLOTS = 64;
	localparam int DEF_WAKE_BATCH   = 64;
	localparam int DEF_TASK_ID_BITS = 8;

	// Fixed widths of the stream fields
	localparam int SPACE_W  = 64;
	localparam int WORD_W   = 64;
	localparam int VALUE_W  = 32;
	localparam int TASK_W   = 8;
	localparam int LIMIT_W  = 7;
	localparam int COUNT_W  = 7;
	localparam int S_DATA_W = 208;
	localparam int M_DATA_W = 16;
	localparam int M_USER_W = 3;

	// Input beat layout, lowest bit of each field
	localparam int OFS_SPACE = 0;
	localparam int OFS_WORD  = OFS_SPACE + SPACE_W;
	localparam int OFS_EXP   = OFS_WORD + WORD_W;
	localparam int OFS_CUR   = OFS_EXP + VALUE_W;
	localparam int OFS_FAULT = OFS_CUR + VALUE_W;
	localparam int OFS_TASK  = OFS_FAULT + 1;
	localparam int OFS_LIMIT = OFS_TASK + TASK_W;

	typedef enum logic {
		REQ_WAIT = 1'b0,
		REQ_WAKE = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_FAULT    = 2'd1,
		STS_MISMATCH = 2'd2,
		STS_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMPACT,
		ST_FLUSH
	} fwq_state_t;

endpackage

`default_nettype wire

### hw/rtl/fwq_store.sv
`default_nettype none

module fwq_store
	import fwq_pkg::*;
#(
	parameter int WAITER_SLOTS = DEF_WAITER_SLOTS,
	parameter int TASK_ID_BITS = DEF_TASK_ID_BITS,
	localparam int IDX_W = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1
) (
	input  wire                     clk,
	input  wire [IDX_W-1:0]         rd_addr,
	input  wire                     wr_en,
	input  wire                     mv_en,
	input  wire [IDX_W-1:0]         wr_addr,
	input  wire [SPACE_W-1:0]       wr_space,
	input  wire [WORD_W-1:0]        wr_word,
	input  wire [TASK_ID_BITS-1:0]  wr_task,
	input  wire [SPACE_W-1:0]       key_space,
	input  wire [WORD_W-1:0]        key_word,
	output logic                    hit,
	output logic [TASK_ID_BITS-1:0] rd_task
);

	localparam int ENT_W = SPACE_W + WORD_W + TASK_ID_BITS;

	logic [ENT_W-1:0] mem [WAITER_SLOTS];
	logic [ENT_W-1:0] rd_q;
	logic [ENT_W-1:0] wdata;

	// Move the entry just read, or store a new waiter
	assign wdata = mv_en ? rd_q : {wr_space, wr_word, wr_task};

	always_ff @(posedge clk) begin
		if (wr_en || mv_en) begin
			mem[wr_addr] <= wdata;
		end
		rd_q <= mem[rd_addr];
	end

	// Shared key compare on the registered read data
	assign hit = (rd_q[ENT_W-1 -: SPACE_W] == key_space) &&
	             (rd_q[TASK_ID_BITS +: WORD_W] == key_word);
	assign rd_task = rd_q[TASK_ID_BITS-1:0];

endmodule

`default_nettype wire

### hw/rtl/futex_wait_queue_table.sv
// Wait request: one result beat, loaded into the output register on the accept edge.
// Wake request: scan newest to oldest at one slot per cycle (stalls only on a full
// output register), then compact the slots above the stop point at one per cycle.
// Input ready only while idle with a free output register.
// Reset clears the waiter count and the sequencer; table contents stay undefined.
`default_nettype none

module futex_wait_queue_table
	import fwq_pkg::*;
#(
	parameter int WAITER_SLOTS = DEF_WAITER_SLOTS,
	parameter int WAKE_BATCH   = DEF_WAKE_BATCH,
	parameter int TASK_ID_BITS = DEF_TASK_ID_BITS
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	// space_id, word_addr, expected_value, current_value, read_fault, task_id, wake_limit
	input  wire [S_DATA_W-1:0]   s_tdata,
	// req_type
	input  wire                  s_tuser,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	// woken_task, woken_count, one zero pad bit
	output logic [M_DATA_W-1:0]  m_tdata,
	// status, task_valid
	output logic [M_USER_W-1:0]  m_tuser,
	output logic                 m_tlast
);

	localparam int CNT_W = $clog2(WAITER_SLOTS + 1);
	localparam int IDX_W = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
	localparam int N_W   = $clog2(WAKE_BATCH + 1);

	fwq_state_t state_q, state_d;

	logic [CNT_W-1:0]        count_q, count_d;
	logic [IDX_W-1:0]        idx_q, idx_d;
	logic [IDX_W-1:0]        wp_q, wp_d;
	logic [N_W-1:0]          n_q, n_d;
	logic [N_W-1:0]          limit_q;
	logic [SPACE_W-1:0]      key_space_q;
	logic [WORD_W-1:0]       key_word_q;
	logic [TASK_ID_BITS-1:0] held_task_q;

	logic                    out_valid_q;
	status_t                 out_status_q;
	logic                    out_tvalid_q;
	logic [TASK_W-1:0]       out_task_q;
	logic [COUNT_W-1:0]      out_cnt_q;
	logic                    out_last_q;

	// Input fields
	logic                    req_wake;
	logic [SPACE_W-1:0]      in_space;
	logic [WORD_W-1:0]       in_word;
	logic [VALUE_W-1:0]      in_exp;
	logic [VALUE_W-1:0]      in_cur;
	logic                    in_fault;
	logic [TASK_ID_BITS-1:0] in_task;
	logic [LIMIT_W-1:0]      in_limit;
	logic [N_W-1:0]          limit_dec;

	// Control
	logic                    take;
	logic                    out_free;
	logic                    hit;
	logic [TASK_ID_BITS-1:0] rd_task;
	logic [IDX_W-1:0]        rd_addr;
	logic                    wr_en;
	logic                    mv_en;
	logic [IDX_W-1:0]        wr_addr;
	logic [CNT_W-1:0]        cnt_m1;
	logic [N_W-1:0]          n_inc;
	logic                    take_hit;
	logic                    scan_end;
	logic                    scan_stop;
	logic                    compact_end;
	status_t                 wait_status;

	logic                    push;
	status_t                 push_status;
	logic                    push_valid;
	logic [TASK_W-1:0]       push_task;
	logic [COUNT_W-1:0]      push_cnt;
	logic                    push_last;

	// Unpack the input beat
	assign req_wake = (s_tuser == REQ_WAKE);
	assign in_space = s_tdata[OFS_SPACE +: SPACE_W];
	assign in_word  = s_tdata[OFS_WORD +: WORD_W];
	assign in_exp   = s_tdata[OFS_EXP +: VALUE_W];
	assign in_cur   = s_tdata[OFS_CUR +: VALUE_W];
	assign in_fault = s_tdata[OFS_FAULT];
	assign in_task  = TASK_ID_BITS'(s_tdata[OFS_TASK +: TASK_W]);
	assign in_limit = s_tdata[OFS_LIMIT +: LIMIT_W];

	// Zero or an oversized limit means a full batch
	assign limit_dec = (in_limit == '0 || in_limit > LIMIT_W'(WAKE_BATCH)) ?
	                   N_W'(WAKE_BATCH) : N_W'(in_limit);

	assign out_free = !out_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign take     = s_tvalid && s_tready;

	assign cnt_m1 = count_q - CNT_W'(1);
	assign n_inc  = n_q + N_W'(1);

	// Wait status in priority order
	always_comb begin
		if (in_fault) begin
			wait_status = STS_FAULT;
		end else if (in_cur != in_exp) begin
			wait_status = STS_MISMATCH;
		end else if (count_q == CNT_W'(WAITER_SLOTS)) begin
			wait_status = STS_FULL;
		end else begin
			wait_status = STS_OK;
		end
	end

	// Scan step: a hit is taken once the held result can move out
	assign take_hit    = hit && (n_q == '0 || out_free);
	assign scan_stop   = take_hit && (n_inc == limit_q);
	assign scan_end    = scan_stop || ((idx_q == '0) && (take_hit || !hit));
	assign compact_end = (CNT_W'(idx_q) == cnt_m1);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take && req_wake) begin
					state_d = (count_q == '0) ? ST_FLUSH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = (take_hit || n_q != '0) ? ST_COMPACT : ST_FLUSH;
				end
			end
			ST_COMPACT: begin
				if (compact_end) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath control per state
	always_comb begin
		rd_addr     = idx_q;
		wr_en       = 1'b0;
		mv_en       = 1'b0;
		wr_addr     = wp_q;
		idx_d       = idx_q;
		wp_d        = wp_q;
		n_d         = n_q;
		count_d     = count_q;
		push        = 1'b0;
		push_status = STS_OK;
		push_valid  = 1'b0;
		push_task   = '0;
		push_cnt    = '0;
		push_last   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				rd_addr = cnt_m1[IDX_W-1:0];
				if (take) begin
					if (req_wake) begin
						n_d   = '0;
						idx_d = cnt_m1[IDX_W-1:0];
					end else begin
						push        = 1'b1;
						push_status = wait_status;
						push_last   = 1'b1;
						if (wait_status == STS_OK) begin
							wr_en   = 1'b1;
							wr_addr = count_q[IDX_W-1:0];
							count_d = count_q + CNT_W'(1);
						end
					end
				end
			end
			ST_SCAN: begin
				// Send the previous hit before holding the new one
				if (take_hit) begin
					n_d = n_inc;
					if (n_q != '0) begin
						push       = 1'b1;
						push_valid = 1'b1;
						push_task  = TASK_W'(held_task_q);
						push_cnt   = COUNT_W'(n_q);
					end
				end
				if (scan_end) begin
					// Slots below the stop point stay untouched
					if (scan_stop) begin
						idx_d = idx_q;
						wp_d  = idx_q;
					end else begin
						idx_d = '0;
						wp_d  = '0;
					end
					rd_addr = idx_d;
				end else if (take_hit || !hit) begin
					idx_d   = idx_q - IDX_W'(1);
					rd_addr = idx_d;
				end
			end
			ST_COMPACT: begin
				// Shift survivors down, drop the matches
				mv_en   = !hit;
				idx_d   = idx_q + IDX_W'(1);
				rd_addr = idx_d;
				wp_d    = wp_q + IDX_W'(!hit);
				if (compact_end) begin
					count_d = CNT_W'(wp_q) + CNT_W'(!hit);
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					push       = 1'b1;
					push_valid = (n_q != '0);
					push_task  = (n_q != '0) ? TASK_W'(held_task_q) : '0;
					push_cnt   = COUNT_W'(n_q);
					push_last  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Sequencer and table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			wp_q    <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			wp_q    <= wp_d;
			n_q     <= n_d;
		end
	end

	// Hold request key and the newest hit
	always_ff @(posedge clk) begin
		if (take) begin
			key_space_q <= in_space;
			key_word_q  <= in_word;
			limit_q     <= limit_dec;
		end
		if (state_q == ST_SCAN && take_hit) begin
			held_task_q <= rd_task;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_tvalid_q <= 1'b0;
		end else if (push) begin
			out_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			out_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_status_q <= push_status;
			out_valid_q  <= push_valid;
			out_task_q   <= push_task;
			out_cnt_q    <= push_cnt;
			out_last_q   <= push_last;
		end
	end

	assign m_tvalid = out_tvalid_q;
	assign m_tdata  = {1'b0, out_cnt_q, out_task_q};
	assign m_tuser  = {out_valid_q, out_status_q};
	assign m_tlast  = out_last_q;

	fwq_store #(
		.WAITER_SLOTS (WAITER_SLOTS),
		.TASK_ID_BITS (TASK_ID_BITS)
	) u_store (
		.clk       (clk),
		.rd_addr   (rd_addr),
		.wr_en     (wr_en),
		.mv_en     (mv_en),
		.wr_addr   (wr_addr),
		.wr_space  (in_space),
		.wr_word   (in_word),
		.wr_task   (in_task),
		.key_space (key_space_q),
		.key_word  (key_word_q),
		.hit       (hit),
		.rd_task   (rd_task)
	);

endmodule

`default_nettype wire
